// ----- hw/rtl/dmpd_pkg.sv -----
// shared types, constants and codes for the dual motor pid drive
`default_nettype none
package dmpd_pkg;

   // channel and register port sizes
   localparam int NUM_CH     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LIM_W      = 15;
   localparam int DT_W       = 9;
   localparam int NUM_W      = 56;
   localparam int Q_W        = 17;
   localparam int DIV_CNT_W  = 5;

   // long-step handling and near-zero stop
   localparam logic [31:0]       DT_JUMP_MS      = 32'd500;
   localparam logic [DT_W-1:0]   DT_JUMP_SUB_MS  = 9'd10;
   localparam logic signed [15:0] NEAR_ZERO_SPEED = 16'sd5;

   // quotient bits of the restoring divider
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(Q_W - 1);

   // register reset values
   localparam logic              USE_PID_RST   = 1'b1;
   localparam logic signed [15:0] GAIN_P_RST    = 16'sd256;
   localparam logic signed [15:0] GAIN_I_RST    = 16'sd0;
   localparam logic signed [15:0] GAIN_D_RST    = 16'sd0;
   localparam logic [LIM_W-1:0]  PWM_LIMIT_RST = 15'd255;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_PID   = 3'd0,
      CSR_GAIN_P    = 3'd1,
      CSR_GAIN_I    = 3'd2,
      CSR_GAIN_D    = 3'd3,
      CSR_PWM_LIMIT = 3'd4
   } csr_idx_type;

   // input word
   typedef struct packed {
      logic              kind;
      logic [31:0]       now_ms;
      logic signed [15:0] left_measured;
      logic signed [15:0] left_target;
      logic signed [15:0] right_measured;
      logic signed [15:0] right_target;
   } req_type;

   // result word
   typedef struct packed {
      logic             left_fwd;
      logic             left_rev;
      logic [LIM_W-1:0] left_duty;
      logic             right_fwd;
      logic             right_rev;
      logic [LIM_W-1:0] right_duty;
   } rsp_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CAPTURE,
      OP_START,
      OP_EDT,
      OP_ACC,
      OP_GP,
      OP_GI,
      OP_SUM,
      OP_SDT,
      OP_GD,
      OP_DM,
      OP_NUM,
      OP_DIV,
      OP_FIN,
      OP_OUT
   } dp_op_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_EDT,
      ST_ACC,
      ST_GP,
      ST_GI,
      ST_SUM,
      ST_SDT,
      ST_GD,
      ST_DM,
      ST_NUM,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      ch;
   } dp_cmd_type;

   typedef struct packed {
      logic bypass;
      logic rsp_busy;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/dmpd_ctrl.sv -----
// sequencer that steps both pid channels through the shared datapath
`default_nettype none
module dmpd_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output dmpd_pkg::dp_cmd_type   cmd,
   input  dmpd_pkg::dp_status_type st
);
   import dmpd_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic                 ch_ff, ch_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
               ch_in    = 1'b0;
            end
         end
         ST_START: begin
            if (!st.bypass) begin
               state_in = ST_EDT;
            end else if (ch_ff) begin
               state_in = ST_OUT;
            end else begin
               ch_in = 1'b1;
            end
         end
         ST_EDT: state_in = ST_ACC;
         ST_ACC: state_in = ST_GP;
         ST_GP:  state_in = ST_GI;
         ST_GI:  state_in = ST_SUM;
         ST_SUM: state_in = ST_SDT;
         ST_SDT: state_in = ST_GD;
         ST_GD:  state_in = ST_DM;
         ST_DM:  state_in = ST_NUM;
         ST_NUM: begin
            state_in = ST_DIV;
            cnt_in   = DIV_LAST;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FIN: begin
            if (ch_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_START;
               ch_in    = 1'b1;
            end
         end
         ST_OUT: begin
            if (!st.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      req_ready = 1'b0;
      cmd.ch    = ch_ff;
      cmd.op    = OP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_CAPTURE;
            end
         end
         ST_START: cmd.op = OP_START;
         ST_EDT:   cmd.op = OP_EDT;
         ST_ACC:   cmd.op = OP_ACC;
         ST_GP:    cmd.op = OP_GP;
         ST_GI:    cmd.op = OP_GI;
         ST_SUM:   cmd.op = OP_SUM;
         ST_SDT:   cmd.op = OP_SDT;
         ST_GD:    cmd.op = OP_GD;
         ST_DM:    cmd.op = OP_DM;
         ST_NUM:   cmd.op = OP_NUM;
         ST_DIV:   cmd.op = OP_DIV;
         ST_FIN:   cmd.op = OP_FIN;
         ST_OUT: begin
            if (!st.rsp_busy) begin
               cmd.op = OP_OUT;
            end
         end
         default: cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/dmpd_dpath.sv -----
// datapath: registers, loop state, multiply steps, divider and result register
`default_nettype none
module dmpd_dpath (
   input  wire                          clock,
   input  wire                          reset,
   input  dmpd_pkg::req_type            req_data,
   input  dmpd_pkg::dp_cmd_type         cmd,
   output dmpd_pkg::dp_status_type      st,
   input  wire                          csr_wr_en,
   input  wire [dmpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [dmpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output dmpd_pkg::rsp_type            rsp_data
);
   import dmpd_pkg::*;

   // configuration
   logic                use_pid_ff, use_pid_in;
   logic signed [15:0]  gain_p_ff, gain_p_in;
   logic signed [15:0]  gain_i_ff, gain_i_in;
   logic signed [15:0]  gain_d_ff, gain_d_in;
   logic [LIM_W-1:0]    lim_ff, lim_in;

   // loop state per channel
   logic signed [31:0]  integ_ff [NUM_CH];
   logic signed [31:0]  integ_in [NUM_CH];
   logic signed [16:0]  prev_ff [NUM_CH];
   logic signed [16:0]  prev_in [NUM_CH];
   logic [31:0]         last_ff [NUM_CH];
   logic [31:0]         last_in [NUM_CH];

   // per channel command
   logic                neg_cmd_ff [NUM_CH];
   logic                neg_cmd_in [NUM_CH];
   logic [LIM_W-1:0]    mag_cmd_ff [NUM_CH];
   logic [LIM_W-1:0]    mag_cmd_in [NUM_CH];

   // working registers
   req_type             in_ff, in_in;
   logic signed [16:0]  e_ff, e_in;
   logic [DT_W-1:0]     dt_ff, dt_in;
   logic signed [26:0]  edt_ff, edt_in;
   logic [24:0]         limk_ff, limk_in;
   logic signed [25:0]  acc_ff, acc_in;
   logic signed [32:0]  gpe_ff, gpe_in;
   logic signed [41:0]  gia_ff, gia_in;
   logic signed [44:0]  s_ff, s_in;
   logic signed [NUM_W-1:0] sdt_ff, sdt_in;
   logic signed [33:0]  gdd_ff, gdd_in;
   logic signed [NUM_W-1:0] dm_ff, dm_in;
   logic [26:0]         den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    dsr_ff, dsr_in;
   logic [Q_W-1:0]      q_ff, q_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // channel view of the captured word
   logic signed [15:0]  tgt, meas;
   logic signed [16:0]  e_w;
   logic [31:0]         dt_raw;
   logic                near, reset_loop, dt_zero;
   logic [15:0]         tgt_abs;
   logic [LIM_W-1:0]    ol_mag;
   logic signed [32:0]  acc_sum, lim_pos, lim_neg;
   logic signed [17:0]  de;
   logic signed [NUM_W-1:0] num;
   logic [LIM_W-1:0]    pid_mag;

   always_comb begin
      tgt     = cmd.ch ? in_ff.right_target : in_ff.left_target;
      meas    = cmd.ch ? in_ff.right_measured : in_ff.left_measured;
      e_w     = 17'(tgt) - 17'(meas);
      dt_raw  = in_ff.now_ms - last_ff[cmd.ch];
      near    = (tgt == 16'sd0) && (meas < NEAR_ZERO_SPEED) && (meas > -NEAR_ZERO_SPEED);
      reset_loop = in_ff.kind || !use_pid_ff || near;
      dt_zero = (dt_raw == '0);
      tgt_abs = tgt[15] ? 16'(-tgt) : 16'(tgt);
      ol_mag  = (tgt_abs > {1'b0, lim_ff}) ? lim_ff : tgt_abs[LIM_W-1:0];
      acc_sum = 33'(integ_ff[cmd.ch]) + 33'(edt_ff);
      lim_pos = $signed({8'd0, limk_ff});
      lim_neg = -lim_pos;
      de      = 18'(e_ff) - 18'(prev_ff[cmd.ch]);
      num     = sdt_ff + dm_ff;
      pid_mag = (q_ff[Q_W-1] || (q_ff[Q_W-2:0] > {1'b0, lim_ff})) ? lim_ff
                                                                  : q_ff[LIM_W-1:0];
   end

   assign st.bypass   = reset_loop || dt_zero;
   assign st.rsp_busy = rsp_valid_ff && !rsp_ready;

   // step logic
   always_comb begin
      use_pid_in = use_pid_ff;
      gain_p_in  = gain_p_ff;
      gain_i_in  = gain_i_ff;
      gain_d_in  = gain_d_ff;
      lim_in     = lim_ff;
      integ_in   = integ_ff;
      prev_in    = prev_ff;
      last_in    = last_ff;
      neg_cmd_in = neg_cmd_ff;
      mag_cmd_in = mag_cmd_ff;
      in_in      = in_ff;
      e_in       = e_ff;
      dt_in      = dt_ff;
      edt_in     = edt_ff;
      limk_in    = limk_ff;
      acc_in     = acc_ff;
      gpe_in     = gpe_ff;
      gia_in     = gia_ff;
      s_in       = s_ff;
      sdt_in     = sdt_ff;
      gdd_in     = gdd_ff;
      dm_in      = dm_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      dsr_in     = dsr_ff;
      q_in       = q_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (cmd.op)
         OP_CAPTURE: in_in = req_data;
         OP_START: begin
            if (reset_loop) begin
               integ_in[cmd.ch] = '0;
               prev_in[cmd.ch]  = '0;
               last_in[cmd.ch]  = in_ff.now_ms;
               if (in_ff.kind || use_pid_ff) begin
                  neg_cmd_in[cmd.ch] = 1'b0;
                  mag_cmd_in[cmd.ch] = '0;
               end else begin
                  neg_cmd_in[cmd.ch] = tgt[15] && (ol_mag != '0);
                  mag_cmd_in[cmd.ch] = ol_mag;
               end
            end else if (dt_zero) begin
               neg_cmd_in[cmd.ch] = 1'b0;
               mag_cmd_in[cmd.ch] = '0;
            end else begin
               e_in  = e_w;
               dt_in = (dt_raw > DT_JUMP_MS) ? DT_JUMP_SUB_MS : dt_raw[DT_W-1:0];
            end
         end
         OP_EDT: begin
            edt_in  = 27'(e_ff) * $signed(27'(dt_ff));
            limk_in = 25'(lim_ff) * 25'd1000;
         end
         OP_ACC: begin
            if (acc_sum > lim_pos) begin
               acc_in = lim_pos[25:0];
            end else if (acc_sum < lim_neg) begin
               acc_in = lim_neg[25:0];
            end else begin
               acc_in = acc_sum[25:0];
            end
         end
         OP_GP:  gpe_in = 33'(gain_p_ff) * 33'(e_ff);
         OP_GI:  gia_in = 42'(gain_i_ff) * 42'(acc_ff);
         OP_SUM: s_in   = 45'(gpe_ff) * 45'sd1000 + 45'(gia_ff);
         OP_SDT: sdt_in = 56'(s_ff) * $signed(56'(dt_ff));
         OP_GD:  gdd_in = 34'(gain_d_ff) * 34'(de);
         OP_DM: begin
            dm_in  = 56'(gdd_ff) * 56'sd1000000;
            den_in = 27'(dt_ff) * 27'd256000;
         end
         OP_NUM: begin
            neg_in = num[NUM_W-1];
            rem_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dsr_in = {13'd0, den_ff, 16'd0};
            q_in   = '0;
         end
         OP_DIV: begin
            if (rem_ff >= dsr_ff) begin
               rem_in = rem_ff - dsr_ff;
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
         end
         OP_FIN: begin
            integ_in[cmd.ch]   = 32'(acc_ff);
            prev_in[cmd.ch]    = e_ff;
            last_in[cmd.ch]    = in_ff.now_ms;
            neg_cmd_in[cmd.ch] = neg_ff && (pid_mag != '0);
            mag_cmd_in[cmd.ch] = pid_mag;
         end
         OP_OUT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.left_fwd    = !neg_cmd_ff[0] && (mag_cmd_ff[0] != '0);
            rsp_in.left_rev    = neg_cmd_ff[0];
            rsp_in.left_duty   = mag_cmd_ff[0];
            rsp_in.right_fwd   = !neg_cmd_ff[1] && (mag_cmd_ff[1] != '0);
            rsp_in.right_rev   = neg_cmd_ff[1];
            rsp_in.right_duty  = mag_cmd_ff[1];
         end
         default: begin
         end
      endcase

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_USE_PID: begin
               use_pid_in = csr_wdata[0];
               if (csr_wdata[0]) begin
                  integ_in[0] = '0;
                  integ_in[1] = '0;
                  prev_in[0]  = '0;
                  prev_in[1]  = '0;
               end
            end
            CSR_GAIN_P:    gain_p_in = $signed(csr_wdata);
            CSR_GAIN_I:    gain_i_in = $signed(csr_wdata);
            CSR_GAIN_D:    gain_d_in = $signed(csr_wdata);
            CSR_PWM_LIMIT: lim_in    = csr_wdata[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         use_pid_ff   <= USE_PID_RST;
         gain_p_ff    <= GAIN_P_RST;
         gain_i_ff    <= GAIN_I_RST;
         gain_d_ff    <= GAIN_D_RST;
         lim_ff       <= PWM_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            integ_ff[i] <= '0;
            prev_ff[i]  <= '0;
            last_ff[i]  <= '0;
         end
      end else begin
         use_pid_ff   <= use_pid_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      neg_cmd_ff <= neg_cmd_in;
      mag_cmd_ff <= mag_cmd_in;
      in_ff      <= in_in;
      e_ff       <= e_in;
      dt_ff      <= dt_in;
      edt_ff     <= edt_in;
      limk_ff    <= limk_in;
      acc_ff     <= acc_in;
      gpe_ff     <= gpe_in;
      gia_ff     <= gia_in;
      s_ff       <= s_in;
      sdt_ff     <= sdt_in;
      gdd_ff     <= gdd_in;
      dm_ff      <= dm_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      q_ff       <= q_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/dual_motor_pid_drive.sv -----
// top level of the dual motor pid drive
// Takes one word at a time: each word runs the left then the right channel
// through one shared multiply-and-divide datapath. A channel that is stopped,
// open loop, near zero or sees no elapsed time takes only the start step. A
// full pid step runs a start step, nine arithmetic steps, the restoring
// divider and a write-back step. The output state then loads the result
// register, and the next word can be accepted in the same cycle that the
// result becomes valid. The result sits in an output register and is held
// until taken; a stalled result holds off the next word's result, not its
// acceptance. The user must write registers through the csr port only while
// no word is in flight; the block itself does not enforce this.
`default_nettype none
module dual_motor_pid_drive (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  dmpd_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output dmpd_pkg::rsp_type              rsp_data,
   input  wire                            csr_wr_en,
   input  wire [dmpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [dmpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dmpd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   // sequencer
   dmpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   // arithmetic and state
   dmpd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/dmpd_checker.sv -----
// port-level checks for the dual motor pid drive, bound to the top level
`default_nettype none
module dmpd_assertions (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input dmpd_pkg::rsp_type              rsp_data
);
   import dmpd_pkg::*;

   // a waiting word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // never both bridge inputs high
   a_left_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.left_fwd && rsp_data.left_rev))
      else $error("left bridge driven both ways");

   a_right_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.right_fwd && rsp_data.right_rev))
      else $error("right bridge driven both ways");

   // zero duty exactly when no direction is set
   a_left_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.left_duty == '0) ==
                     (!rsp_data.left_fwd && !rsp_data.left_rev)))
      else $error("left duty and direction disagree");

   a_right_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.right_duty == '0) ==
                     (!rsp_data.right_fwd && !rsp_data.right_rev)))
      else $error("right duty and direction disagree");

endmodule

bind dual_motor_pid_drive dmpd_assertions u_dmpd_assertions (.*);
`default_nettype wire
